// ===== design/ttceb_pkg.sv =====
// ----------------------------------------------------------------------------
// ttceb_pkg
// Shared types, register indexes, reset values and codes of the
// time-to-collision emergency brake.
// ----------------------------------------------------------------------------
package ttceb_pkg;

    localparam int unsigned SCAN_POINTS_DEF = 2048;

    // input item kinds
    localparam logic [1:0] KIND_SPEED = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    // result kinds
    localparam logic RESULT_SCAN = 1'b0;
    localparam logic RESULT_TICK = 1'b1;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_START = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_END = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_ORIGIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TTC_THRESHOLD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_TICKS = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_TICKS = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_SPEED = 3'd7;

    // reset values
    localparam logic [10:0] RST_WINDOW_START = 11'd2020;
    localparam logic [10:0] RST_WINDOW_END = 11'd28;
    localparam logic signed [31:0] RST_ANGLE_ORIGIN = -32'sd205887;
    localparam logic [15:0] RST_ANGLE_STEP = 16'd201;
    localparam logic [15:0] RST_TTC_THRESHOLD = 16'd512;
    localparam logic [15:0] RST_HOLDOFF_TICKS = 16'd5;
    localparam logic [15:0] RST_RECOVERY_TICKS = 16'd2;
    localparam logic signed [15:0] RST_RECOVERY_SPEED = -16'sd500;

    localparam logic [15:0] NO_RETURN = 16'hFFFF;

    // evaluation queue between front and back
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [10:0]        window_start;
        logic [10:0]        window_end;
        logic signed [31:0] angle_origin;
        logic [15:0]        angle_step;
        logic [15:0]        ttc_threshold;
        logic [15:0]        holdoff_ticks;
        logic [15:0]        recovery_ticks;
        logic signed [15:0] recovery_speed;
    } cfg_t;

    // one pending evaluation: a finished scan or a time tick
    typedef struct packed {
        logic               is_tick;
        logic               found;
        logic [15:0]        range_mm;
        logic [10:0]        index;
        logic signed [15:0] speed;
    } job_t;

    typedef struct packed {
        logic               result_kind;
        logic               obstacle_found;
        logic               brake_condition;
        logic               recovery_started;
        logic               recovery_active;
        logic signed [15:0] drive_command_mm_s;
        logic [15:0]        nearest_range_mm;
        logic [10:0]        nearest_index;
    } result_t;

endpackage

// ===== design/ttceb_front.sv =====
// ----------------------------------------------------------------------------
// ttceb_front
// Accepts input transactions, stores the speed command, tracks the nearest
// return inside the front window and queues an evaluation job per finished
// scan or time tick.
// ----------------------------------------------------------------------------
module ttceb_front import ttceb_pkg::*; #(
    parameter int unsigned SCAN_POINTS = SCAN_POINTS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [1:0]         s_kind,
    input  logic signed [15:0] s_speed_mm_s,
    input  logic [15:0]        s_range_mm,
    input  logic [10:0]        s_sample_index,
    input  logic               s_last_sample,
    output logic               push,
    output job_t               push_job,
    input  logic               queue_full
);

    localparam logic [16:0] LAST_IDX = 17'(SCAN_POINTS - 1);
    localparam logic [16:0] NUM_IDX = 17'(SCAN_POINTS);

    logic signed [15:0] speed_reg;
    logic [15:0]        best_range_reg;
    logic [10:0]        best_index_reg;
    logic               best_upper_reg;

    logic [16:0] win_s, win_e, idx;
    logic        upper, in_window, earlier, take, accept;
    logic [15:0] best_range_next;
    logic [10:0] best_index_next;
    logic        best_upper_next;

    assign s_ready = !queue_full;
    assign accept = s_valid && s_ready;

    always_comb begin
        win_s = ({6'b0, cfg.window_start} > LAST_IDX) ? LAST_IDX : {6'b0, cfg.window_start};
        win_e = ({6'b0, cfg.window_end} > LAST_IDX) ? LAST_IDX : {6'b0, cfg.window_end};
        idx = {6'b0, s_sample_index};
        if (win_s <= win_e) begin
            upper = 1'b1;
            in_window = (idx >= win_s) && (idx <= win_e);
        end else begin
            upper = (idx >= win_s);
            in_window = (idx >= win_s) || (idx <= win_e);
        end
        if (best_range_reg == NO_RETURN) begin
            earlier = 1'b1;
        end else begin
            earlier = (upper && !best_upper_reg) ||
                      ((upper == best_upper_reg) && (s_sample_index < best_index_reg));
        end
        take = (idx < NUM_IDX) && (s_range_mm != NO_RETURN) && in_window &&
               ((s_range_mm < best_range_reg) || ((s_range_mm == best_range_reg) && earlier));
        best_range_next = take ? s_range_mm : best_range_reg;
        best_index_next = take ? s_sample_index : best_index_reg;
        best_upper_next = take ? upper : best_upper_reg;
    end

    always_comb begin
        push = 1'b0;
        push_job.is_tick = 1'b0;
        push_job.found = (best_range_next != NO_RETURN);
        push_job.range_mm = best_range_next;
        push_job.index = (best_range_next != NO_RETURN) ? best_index_next : 11'd0;
        push_job.speed = speed_reg;
        if (accept) begin
            case (s_kind)
                KIND_SAMPLE: push = s_last_sample;
                KIND_TICK: begin
                    push = 1'b1;
                    push_job.is_tick = 1'b1;
                end
                default: push = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg <= '0;
            best_range_reg <= NO_RETURN;
            best_index_reg <= '0;
            best_upper_reg <= 1'b0;
        end else if (accept) begin
            if (s_kind == KIND_SPEED) begin
                speed_reg <= s_speed_mm_s;
            end else if (s_kind == KIND_SAMPLE) begin
                if (s_last_sample) begin
                    // scan done: accumulator back to empty
                    best_range_reg <= NO_RETURN;
                    best_index_reg <= '0;
                    best_upper_reg <= 1'b0;
                end else begin
                    best_range_reg <= best_range_next;
                    best_index_reg <= best_index_next;
                    best_upper_reg <= best_upper_next;
                end
            end
        end
    end

endmodule

// ===== design/ttceb_queue.sv =====
// ----------------------------------------------------------------------------
// ttceb_queue
// Short first-in first-out queue of evaluation jobs between front and back.
// ----------------------------------------------------------------------------
module ttceb_queue import ttceb_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output logic pop_valid,
    output job_t pop_job
);

    job_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic              do_push, do_pop;

    assign full = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_job = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && pop_valid;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/ttceb_back.sv =====
// ----------------------------------------------------------------------------
// ttceb_back
// Sequencer that evaluates queued jobs: angle, cosine approximation and
// time-to-collision product over one shared multiplier, then the holdoff and
// recovery timers and the result register.
// ----------------------------------------------------------------------------
module ttceb_back import ttceb_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  cfg_t    cfg,
    input  logic    job_valid,
    input  job_t    job,
    output logic    job_pop,
    output logic    m_valid,
    input  logic    m_ready,
    output result_t m_result
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MUL_IDX = 4'd1;
    localparam logic [3:0] ST_THETA = 4'd2;
    localparam logic [3:0] ST_MAG = 4'd3;
    localparam logic [3:0] ST_SQUARE = 4'd4;
    localparam logic [3:0] ST_COS = 4'd5;
    localparam logic [3:0] ST_MUL_TS = 4'd6;
    localparam logic [3:0] ST_MUL_COS = 4'd7;
    localparam logic [3:0] ST_DECIDE = 4'd8;

    logic [3:0]         state_reg;
    job_t               job_reg;
    logic [47:0]        acc_reg;
    logic signed [33:0] theta_reg;
    logic [16:0]        mag_reg;
    logic               far_reg;
    logic [16:0]        cos_reg;
    logic [15:0]        holdoff_reg;
    logic [15:0]        left_reg;
    logic               recovering_reg;
    logic               out_valid_reg;
    result_t            out_reg;

    logic [30:0] mul_a;
    logic [16:0] mul_b;
    logic [47:0] mul_p;
    logic [33:0] theta_abs;
    logic [16:0] half;
    logic        out_free, speed_pos, brake, started;
    logic [15:0] left_dec;

    assign job_pop = (state_reg == ST_IDLE) && job_valid;
    assign out_free = !out_valid_reg || m_ready;
    assign m_valid = out_valid_reg;
    assign m_result = out_reg;

    // shared multiplier, operands chosen by the step
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_MUL_IDX: begin
                mul_a = {15'b0, cfg.angle_step};
                mul_b = {6'b0, job_reg.index};
            end
            ST_SQUARE: begin
                mul_a = {14'b0, mag_reg};
                mul_b = mag_reg;
            end
            ST_MUL_TS: begin
                mul_a = {15'b0, cfg.ttc_threshold};
                mul_b = {2'b0, job_reg.speed[14:0]};
            end
            ST_MUL_COS: begin
                mul_a = acc_reg[30:0];
                mul_b = cos_reg;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end
    assign mul_p = {17'b0, mul_a} * {31'b0, mul_b};

    assign theta_abs = theta_reg[33] ? 34'(-theta_reg) : 34'(theta_reg);
    assign half = acc_reg[33:17];
    assign speed_pos = !job_reg.speed[15] && (job_reg.speed != '0);
    assign brake = job_reg.found && speed_pos && !far_reg &&
                   ({8'b0, job_reg.range_mm, 24'b0} < acc_reg);
    assign started = brake && (holdoff_reg >= cfg.holdoff_ticks);
    assign left_dec = (left_reg != '0) ? left_reg - 1'b1 : left_reg;

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                if (job_valid) begin
                    job_reg <= job;
                    far_reg <= 1'b0;
                end
            end
            ST_MUL_IDX: acc_reg <= mul_p;
            ST_THETA: theta_reg <= {{2{cfg.angle_origin[31]}}, cfg.angle_origin} +
                                   {7'b0, acc_reg[26:0]};
            ST_MAG: begin
                mag_reg <= theta_abs[16:0];
                // angle too large: cosine approximation not positive
                far_reg <= |theta_abs[33:17];
            end
            ST_SQUARE: acc_reg <= mul_p;
            ST_COS: begin
                if (half[16]) begin
                    far_reg <= 1'b1;
                end
                cos_reg <= 17'h10000 - half;
            end
            ST_MUL_TS: acc_reg <= mul_p;
            ST_MUL_COS: acc_reg <= mul_p;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            holdoff_reg <= '0;
            left_reg <= '0;
            recovering_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (state_reg == ST_DECIDE && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        state_reg <= job.is_tick ? ST_DECIDE : ST_MUL_IDX;
                    end
                end
                ST_MUL_IDX: state_reg <= ST_THETA;
                ST_THETA: state_reg <= ST_MAG;
                ST_MAG: state_reg <= ST_SQUARE;
                ST_SQUARE: state_reg <= ST_COS;
                ST_COS: state_reg <= ST_MUL_TS;
                ST_MUL_TS: state_reg <= ST_MUL_COS;
                ST_MUL_COS: state_reg <= ST_DECIDE;
                ST_DECIDE: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                        if (job_reg.is_tick) begin
                            if (recovering_reg) begin
                                left_reg <= left_dec;
                                if (left_dec == '0) begin
                                    recovering_reg <= 1'b0;
                                end
                            end else if (holdoff_reg != 16'hFFFF) begin
                                holdoff_reg <= holdoff_reg + 1'b1;
                            end
                        end else if (started) begin
                            holdoff_reg <= '0;
                            left_reg <= cfg.recovery_ticks;
                            recovering_reg <= (cfg.recovery_ticks != '0);
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (state_reg == ST_DECIDE && out_free) begin
            if (job_reg.is_tick) begin
                out_reg.result_kind <= RESULT_TICK;
                out_reg.obstacle_found <= 1'b0;
                out_reg.brake_condition <= 1'b0;
                out_reg.recovery_started <= 1'b0;
                out_reg.recovery_active <= recovering_reg;
                out_reg.drive_command_mm_s <= recovering_reg ? cfg.recovery_speed : '0;
                out_reg.nearest_range_mm <= NO_RETURN;
                out_reg.nearest_index <= '0;
            end else begin
                out_reg.result_kind <= RESULT_SCAN;
                out_reg.obstacle_found <= job_reg.found;
                out_reg.brake_condition <= brake;
                out_reg.recovery_started <= started;
                if (started) begin
                    out_reg.recovery_active <= (cfg.recovery_ticks != '0);
                    out_reg.drive_command_mm_s <= (cfg.recovery_ticks != '0) ?
                                                  cfg.recovery_speed : '0;
                end else begin
                    out_reg.recovery_active <= recovering_reg;
                    out_reg.drive_command_mm_s <= recovering_reg ? cfg.recovery_speed : '0;
                end
                out_reg.nearest_range_mm <= job_reg.range_mm;
                out_reg.nearest_index <= job_reg.index;
            end
        end
    end

endmodule

// ===== design/ttc_emergency_brake.sv =====
// ----------------------------------------------------------------------------
// ttc_emergency_brake
// Time-to-collision emergency brake with lidar front-window search and a
// timed backing-up recovery.
// ----------------------------------------------------------------------------
// Speed commands, scan samples and ticks are taken at one transaction per
// clock cycle; the front keeps the nearest return of the current scan with a
// single compare per sample. A last sample or a tick queues an evaluation in a
// four-entry queue, and the back sequencer works through it with one shared
// 31x17 multiplier: a scan evaluation steps through angle, cosine
// approximation, time-to-collision product and decision, and a tick goes
// straight to the decision; both may wait for the result to be taken. The
// input stalls only when four evaluations are pending. Configuration writes
// are accepted in every cycle and must be made while the block is idle.
// ----------------------------------------------------------------------------
module ttc_emergency_brake import ttceb_pkg::*; #(
    parameter int unsigned SCAN_POINTS = SCAN_POINTS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_kind,
    input  logic signed [15:0]   s_speed_mm_s,
    input  logic [15:0]          s_range_mm,
    input  logic [10:0]          s_sample_index,
    input  logic                 s_last_sample,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_result_kind,
    output logic                 m_obstacle_found,
    output logic                 m_brake_condition,
    output logic                 m_recovery_started,
    output logic                 m_recovery_active,
    output logic signed [15:0]   m_drive_command_mm_s,
    output logic [15:0]          m_nearest_range_mm,
    output logic [10:0]          m_nearest_index
);

    cfg_t    cfg_reg;
    logic    push, queue_full, job_valid, job_pop;
    job_t    push_job, job;
    result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.window_start <= RST_WINDOW_START;
            cfg_reg.window_end <= RST_WINDOW_END;
            cfg_reg.angle_origin <= RST_ANGLE_ORIGIN;
            cfg_reg.angle_step <= RST_ANGLE_STEP;
            cfg_reg.ttc_threshold <= RST_TTC_THRESHOLD;
            cfg_reg.holdoff_ticks <= RST_HOLDOFF_TICKS;
            cfg_reg.recovery_ticks <= RST_RECOVERY_TICKS;
            cfg_reg.recovery_speed <= RST_RECOVERY_SPEED;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_WINDOW_START: cfg_reg.window_start <= cfg_data[10:0];
                REG_WINDOW_END: cfg_reg.window_end <= cfg_data[10:0];
                REG_ANGLE_ORIGIN: cfg_reg.angle_origin <= cfg_data;
                REG_ANGLE_STEP: cfg_reg.angle_step <= cfg_data[15:0];
                REG_TTC_THRESHOLD: cfg_reg.ttc_threshold <= cfg_data[15:0];
                REG_HOLDOFF_TICKS: cfg_reg.holdoff_ticks <= cfg_data[15:0];
                REG_RECOVERY_TICKS: cfg_reg.recovery_ticks <= cfg_data[15:0];
                REG_RECOVERY_SPEED: cfg_reg.recovery_speed <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    ttceb_front #(
        .SCAN_POINTS(SCAN_POINTS)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_kind        (s_kind),
        .s_speed_mm_s  (s_speed_mm_s),
        .s_range_mm    (s_range_mm),
        .s_sample_index(s_sample_index),
        .s_last_sample (s_last_sample),
        .push          (push),
        .push_job      (push_job),
        .queue_full    (queue_full)
    );

    ttceb_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .full     (queue_full),
        .pop      (job_pop),
        .pop_valid(job_valid),
        .pop_job  (job)
    );

    ttceb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .job_valid(job_valid),
        .job      (job),
        .job_pop  (job_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    assign m_result_kind = result.result_kind;
    assign m_obstacle_found = result.obstacle_found;
    assign m_brake_condition = result.brake_condition;
    assign m_recovery_started = result.recovery_started;
    assign m_recovery_active = result.recovery_active;
    assign m_drive_command_mm_s = result.drive_command_mm_s;
    assign m_nearest_range_mm = result.nearest_range_mm;
    assign m_nearest_index = result.nearest_index;

endmodule

// ===== bench/brake_checker.sv =====
// ----------------------------------------------------------------------------
// brake_checker
// Watches the configuration, input and result channels of the emergency
// brake, keeps its own copy of the settings and scan state, works out the
// result of every accepted input transaction and compares each accepted
// result with the oldest outstanding one, field by field.
// ----------------------------------------------------------------------------
module brake_checker import ttceb_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic [1:0]           s_kind,
    input  logic signed [15:0]   s_speed_mm_s,
    input  logic [15:0]          s_range_mm,
    input  logic [10:0]          s_sample_index,
    input  logic                 s_last_sample,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic                 m_result_kind,
    input  logic                 m_obstacle_found,
    input  logic                 m_brake_condition,
    input  logic                 m_recovery_started,
    input  logic                 m_recovery_active,
    input  logic signed [15:0]   m_drive_command_mm_s,
    input  logic [15:0]          m_nearest_range_mm,
    input  logic [10:0]          m_nearest_index,
    output int                   fail_count,
    output int                   pending
);

    // settings
    logic [10:0]        win_lo;
    logic [10:0]        win_hi;
    logic signed [31:0] ang_org;
    logic [15:0]        ang_stp;
    logic [15:0]        ttc_lim;
    logic [15:0]        hold_min;
    logic [15:0]        back_len;
    logic signed [15:0] back_spd;

    // running state
    logic signed [15:0] spd_cmd;
    logic [15:0]        near_rng;
    logic [10:0]        near_idx;
    bit                 near_hi;
    logic [15:0]        hold_cnt;
    logic [15:0]        back_left;
    bit                 backing;

    result_t due_results[$];

    function void clear_scan();
        near_rng = NO_RETURN;
        near_idx = '0;
        near_hi = 1'b0;
    endfunction

    // keep the nearest return of the front window, ties to the first in window order
    function void take_return(input logic [15:0] rng, input logic [10:0] idx);
        bit in_win;
        bit upper;
        bit ahead;
        if (rng == NO_RETURN)
            return;
        if (win_lo <= win_hi) begin
            in_win = idx >= win_lo && idx <= win_hi;
            upper = 1'b1;
        end else begin
            upper = idx >= win_lo;
            in_win = idx >= win_lo || idx <= win_hi;
        end
        if (!in_win)
            return;
        ahead = (near_rng == NO_RETURN) || (upper && !near_hi) ||
                (upper == near_hi && idx < near_idx);
        if (rng < near_rng || (rng == near_rng && ahead)) begin
            near_rng = rng;
            near_idx = idx;
            near_hi = upper;
        end
    endfunction

    // range < threshold * speed * cos(theta), cos as 1 - theta^2/2 in Q16
    function bit closing_fast();
        longint      theta;
        logic [63:0] mag;
        logic [63:0] half;
        logic [63:0] cosq;
        logic [63:0] prod;
        if (near_rng == NO_RETURN || spd_cmd <= 0)
            return 1'b0;
        theta = longint'(ang_org) + longint'(near_idx) * longint'(ang_stp);
        mag = (theta < 0) ? -theta : theta;
        half = (mag * mag) >> 17;
        if (half >= 64'd65536)
            return 1'b0;
        cosq = 64'd65536 - half;
        prod = {48'd0, ttc_lim} * {48'd0, spd_cmd} * cosq;
        return {24'd0, near_rng, 24'd0} < prod;
    endfunction

    function bit step_brake(input logic [1:0] kind, input logic signed [15:0] spd,
                            input logic [15:0] rng, input logic [10:0] idx,
                            input logic lst, output result_t res);
        bit found;
        bit brake;
        bit started;
        res = '0;
        case (kind)
            KIND_SPEED: begin
                spd_cmd = spd;
                return 1'b0;
            end
            KIND_SAMPLE: begin
                take_return(rng, idx);
                if (!lst)
                    return 1'b0;
                found = near_rng != NO_RETURN;
                brake = closing_fast();
                started = 1'b0;
                if (brake && hold_cnt >= hold_min) begin
                    started = 1'b1;
                    hold_cnt = '0;
                    back_left = back_len;
                    backing = back_len != 0;
                end
                res.result_kind = RESULT_SCAN;
                res.obstacle_found = found;
                res.brake_condition = brake;
                res.recovery_started = started;
                res.recovery_active = backing;
                res.drive_command_mm_s = backing ? back_spd : 16'sd0;
                res.nearest_range_mm = near_rng;
                res.nearest_index = found ? near_idx : 11'd0;
                clear_scan();
                return 1'b1;
            end
            KIND_TICK: begin
                // status is reported as it stood before the tick
                res.result_kind = RESULT_TICK;
                res.recovery_active = backing;
                res.drive_command_mm_s = backing ? back_spd : 16'sd0;
                res.nearest_range_mm = NO_RETURN;
                res.nearest_index = '0;
                if (backing) begin
                    if (back_left > 0)
                        back_left = back_left - 1'b1;
                    if (back_left == 0)
                        backing = 1'b0;
                end else if (hold_cnt != 16'hFFFF) begin
                    hold_cnt = hold_cnt + 1'b1;
                end
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function void check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : watch
        result_t want;
        result_t got;
        bit      made;
        if (!aresetn) begin
            win_lo = RST_WINDOW_START;
            win_hi = RST_WINDOW_END;
            ang_org = RST_ANGLE_ORIGIN;
            ang_stp = RST_ANGLE_STEP;
            ttc_lim = RST_TTC_THRESHOLD;
            hold_min = RST_HOLDOFF_TICKS;
            back_len = RST_RECOVERY_TICKS;
            back_spd = RST_RECOVERY_SPEED;
            spd_cmd = '0;
            clear_scan();
            hold_cnt = '0;
            back_left = '0;
            backing = 1'b0;
            fail_count = 0;
            due_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_WINDOW_START:   win_lo = cfg_data[10:0];
                    REG_WINDOW_END:     win_hi = cfg_data[10:0];
                    REG_ANGLE_ORIGIN:   ang_org = cfg_data;
                    REG_ANGLE_STEP:     ang_stp = cfg_data[15:0];
                    REG_TTC_THRESHOLD:  ttc_lim = cfg_data[15:0];
                    REG_HOLDOFF_TICKS:  hold_min = cfg_data[15:0];
                    REG_RECOVERY_TICKS: back_len = cfg_data[15:0];
                    REG_RECOVERY_SPEED: back_spd = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                got = {m_result_kind, m_obstacle_found, m_brake_condition,
                       m_recovery_started, m_recovery_active, m_drive_command_mm_s,
                       m_nearest_range_mm, m_nearest_index};
                if (due_results.size() == 0) begin
                    $error("result transaction with nothing outstanding");
                    fail_count++;
                end else begin
                    want = due_results.pop_front();
                    check_field("result_kind", want.result_kind, got.result_kind);
                    check_field("obstacle_found", want.obstacle_found, got.obstacle_found);
                    check_field("brake_condition", want.brake_condition,
                                got.brake_condition);
                    check_field("recovery_started", want.recovery_started,
                                got.recovery_started);
                    check_field("recovery_active", want.recovery_active,
                                got.recovery_active);
                    check_field("drive_command_mm_s", want.drive_command_mm_s,
                                got.drive_command_mm_s);
                    check_field("nearest_range_mm", want.nearest_range_mm,
                                got.nearest_range_mm);
                    check_field("nearest_index", want.nearest_index, got.nearest_index);
                end
            end
            if (s_valid && s_ready) begin
                made = step_brake(s_kind, s_speed_mm_s, s_range_mm, s_sample_index,
                                  s_last_sample, want);
                if (made)
                    due_results = {due_results, want};
            end
        end
        pending = due_results.size();
    end

endmodule

// ===== bench/tb_ttc_emergency_brake.sv =====
// ----------------------------------------------------------------------------
// tb_ttc_emergency_brake
// Stimulus and verdict for the time-to-collision emergency brake.
// ----------------------------------------------------------------------------
// A directed opening covers reset settings, wrapped window ties, empty and
// out-of-window scans, braking with recovery and the unused kind. Then several
// phases, each with its own settings (extremes among them), send short scans
// mixed with speed commands and ticks, with random gaps on both channels.
// Checking is done by brake_checker beside the block.
// ----------------------------------------------------------------------------
module tb_ttc_emergency_brake import ttceb_pkg::*; ();

    localparam int         CYCLE_LIMIT = 400000;
    localparam int         PHASE_ITEMS = 120;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]          cfg_data;
    logic                 s_valid;
    logic                 s_ready;
    logic [1:0]           s_kind;
    logic signed [15:0]   s_speed_mm_s;
    logic [15:0]          s_range_mm;
    logic [10:0]          s_sample_index;
    logic                 s_last_sample;
    logic                 m_valid;
    logic                 m_ready;
    logic                 m_result_kind;
    logic                 m_obstacle_found;
    logic                 m_brake_condition;
    logic                 m_recovery_started;
    logic                 m_recovery_active;
    logic signed [15:0]   m_drive_command_mm_s;
    logic [15:0]          m_nearest_range_mm;
    logic [10:0]          m_nearest_index;
    int                   fail_count;
    int                   pending;

    bit quiet = 1'b0;
    int cycles = 0;

    ttc_emergency_brake dut (.*);

    brake_checker scoreboard (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("[ttc_emergency_brake] ERROR");
            $finish;
        end
    end

    // mostly short gaps, a few long ones, none while quiet
    function automatic int idle_len(input int long_max);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, long_max);
    endfunction

    initial begin : sink
        int stall;
        m_ready <= 1'b0;
        @(negedge aclk);
        forever begin
            stall = idle_len(40);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge aclk);
        end
    end

    task automatic send(input logic [1:0] k, input logic [15:0] spd, input logic [15:0] rng,
                        input logic [10:0] idx, input logic lst);
        int gap;
        gap = idle_len(30);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= k;
        s_speed_mm_s <= spd;
        s_range_mm <= rng;
        s_sample_index <= idx;
        s_last_sample <= lst;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // stop sending until every result is back, then let the back end go quiet
    task automatic settle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0) @(negedge aclk);
        repeat (40) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value,
                             input logic [31:0] mask);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= (value & mask) | ($urandom() & ~mask);
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_config(input cfg_t c);
        write_reg(REG_WINDOW_START, {21'd0, c.window_start}, 32'h0000_07FF);
        write_reg(REG_WINDOW_END, {21'd0, c.window_end}, 32'h0000_07FF);
        write_reg(REG_ANGLE_ORIGIN, c.angle_origin, 32'hFFFF_FFFF);
        write_reg(REG_ANGLE_STEP, {16'd0, c.angle_step}, 32'h0000_FFFF);
        write_reg(REG_TTC_THRESHOLD, {16'd0, c.ttc_threshold}, 32'h0000_FFFF);
        write_reg(REG_HOLDOFF_TICKS, {16'd0, c.holdoff_ticks}, 32'h0000_FFFF);
        write_reg(REG_RECOVERY_TICKS, {16'd0, c.recovery_ticks}, 32'h0000_FFFF);
        write_reg(REG_RECOVERY_SPEED, {16'd0, c.recovery_speed}, 32'h0000_FFFF);
        cfg_valid <= 1'b0;
    endtask

    function automatic cfg_t phase_setup(input int p);
        cfg_t c;
        int   center;
        int   hw;
        int   stp;
        // random window around a center, angle close to zero at the center
        center = $urandom_range(0, 2047);
        hw = $urandom_range(0, 40);
        stp = $urandom_range(0, 600);
        c.window_start = 11'(center - hw);
        c.window_end = 11'(center + hw);
        c.angle_origin = -(center * stp) + $urandom_range(0, 4000) - 2000;
        c.angle_step = 16'(stp);
        c.ttc_threshold = 16'($urandom_range(128, 2048));
        c.holdoff_ticks = 16'($urandom_range(0, 4));
        c.recovery_ticks = 16'($urandom_range(0, 6));
        c.recovery_speed = 16'($urandom());
        case (p)
            1: begin
                c.window_start = 11'd1000;
                c.window_end = 11'd1050;
                c.angle_origin = -32'sd205824;
                c.angle_step = 16'd201;
                c.ttc_threshold = 16'd512;
                c.holdoff_ticks = 16'd0;
                c.recovery_ticks = 16'd3;
                c.recovery_speed = -16'sd500;
            end
            2: begin
                c.window_start = 11'd2047;
                c.window_end = 11'd0;
                c.angle_origin = 32'sh8000_0000;
                c.angle_step = 16'd0;
                c.ttc_threshold = 16'd0;
                c.holdoff_ticks = 16'd0;
                c.recovery_ticks = 16'd0;
                c.recovery_speed = 16'sh8000;
            end
            3: begin
                c.window_start = 11'd0;
                c.window_end = 11'd2047;
                c.angle_origin = 32'sh7FFF_FFFF;
                c.angle_step = 16'hFFFF;
                c.ttc_threshold = 16'hFFFF;
                c.holdoff_ticks = 16'hFFFF;
                c.recovery_ticks = 16'hFFFF;
                c.recovery_speed = 16'sh7FFF;
            end
            4: begin
                // wrapped window, zero angle at index 2044
                c.window_start = 11'd2040;
                c.window_end = 11'd8;
                c.angle_origin = -32'sd6132;
                c.angle_step = 16'd3;
                c.ttc_threshold = 16'd700;
                c.holdoff_ticks = 16'd2;
                c.recovery_ticks = 16'd1;
            end
            5: begin
                c.ttc_threshold = 16'hFFFF;
                c.holdoff_ticks = 16'd0;
                c.recovery_ticks = 16'hFFFF;
            end
            7: begin
                c.ttc_threshold = 16'd4000;
                c.holdoff_ticks = 16'd0;
                c.recovery_ticks = 16'd0;
            end
            default: ;
        endcase
        return c;
    endfunction

    // short scans mixed with speed commands, ticks and a little noise
    task automatic run_phase(input cfg_t c, input int n);
        int          done;
        int          left;
        int          r;
        int          span;
        int          tie_rng;
        bit          paused;
        logic [15:0] spd;
        logic [15:0] rng;
        logic [10:0] idx;
        done = 0;
        left = 0;
        tie_rng = 0;
        paused = 1'b0;
        if (c.window_start <= c.window_end)
            span = int'(c.window_end) - int'(c.window_start) + 1;
        else
            span = 2049 - int'(c.window_start) + int'(c.window_end);
        while (done < n || left > 0) begin
            if (done % 40 == 0)
                quiet = ($urandom_range(0, 3) == 0);
            if (!paused && done >= n / 2) begin
                settle();
                paused = 1'b1;
            end
            r = $urandom_range(0, 99);
            if (done < n && r < 12) begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    spd = 16'($urandom_range(1, 3000));
                else if (r == 7)
                    spd = 16'(-int'($urandom_range(0, 3000)));
                else
                    spd = 16'($urandom());
                send(KIND_SPEED, spd, 16'($urandom()), 11'($urandom()), 1'($urandom()));
                done++;
            end else if (done < n && r < 28) begin
                send(KIND_TICK, 16'($urandom()), 16'($urandom()), 11'($urandom()),
                     1'($urandom()));
                done++;
            end else if (done < n && r < 30) begin
                send(KIND_SPARE, 16'($urandom()), 16'($urandom()), 11'($urandom()),
                     1'($urandom()));
            end else begin
                if (left == 0) begin
                    left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12)
                                                       : $urandom_range(1, 4);
                    tie_rng = $urandom_range(0, 6000);
                end
                if ($urandom_range(0, 99) < 80)
                    idx = 11'(int'(c.window_start) + $urandom_range(0, span - 1));
                else
                    idx = 11'($urandom());
                r = $urandom_range(0, 99);
                if (r < 10)
                    rng = NO_RETURN;
                else if (r < 35)
                    rng = 16'(tie_rng);
                else if (r < 50)
                    rng = 16'($urandom());
                else
                    rng = 16'($urandom_range(0, 6000));
                send(KIND_SAMPLE, 16'($urandom()), rng, idx, left == 1);
                left--;
                done++;
            end
        end
    endtask

    initial begin : stimulus
        cfg_t cur;
        aresetn <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_WINDOW_START;
        cfg_data <= '0;
        s_valid <= 1'b0;
        s_kind <= KIND_SPEED;
        s_speed_mm_s <= '0;
        s_range_mm <= '0;
        s_sample_index <= '0;
        s_last_sample <= 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset settings: wrapped window 2020..28, angles near pi so never braking
        send(KIND_TICK, 16'd0, 16'd0, 11'd0, 1'b0);
        send(KIND_SPEED, 16'h7FFF, 16'd0, 11'd0, 1'b0);
        send(KIND_SAMPLE, 16'd0, NO_RETURN, 11'd2047, 1'b0);
        send(KIND_SAMPLE, 16'd0, 16'd0, 11'd29, 1'b0);
        send(KIND_SAMPLE, 16'd0, 16'd700, 11'd0, 1'b0);
        // same range in the upper part comes first in window order
        send(KIND_SAMPLE, 16'd0, 16'd700, 11'd2020, 1'b0);
        send(KIND_SAMPLE, 16'd0, 16'd700, 11'd28, 1'b1);
        send(KIND_SAMPLE, 16'd0, 16'd5, 11'd100, 1'b1);
        send(KIND_SPARE, 16'hFFFF, 16'hFFFF, 11'h7FF, 1'b1);
        send(KIND_SPEED, 16'h8000, 16'd0, 11'd0, 1'b0);
        settle();

        cur = phase_setup(1);
        write_config(cur);
        send(KIND_SPEED, 16'd1000, 16'd0, 11'd0, 1'b0);
        send(KIND_SAMPLE, 16'd0, 16'd100, 11'd1024, 1'b0);
        send(KIND_SAMPLE, 16'd0, 16'd100, 11'd1030, 1'b1);
        repeat (4) send(KIND_TICK, 16'd0, 16'd0, 11'd0, 1'b0);
        send(KIND_SAMPLE, 16'd0, 16'd0, 11'd1050, 1'b1);
        send(KIND_SPEED, 16'd0, 16'd0, 11'd0, 1'b0);
        send(KIND_SAMPLE, 16'd0, 16'd65534, 11'd1000, 1'b1);
        send(KIND_SAMPLE, 16'd0, NO_RETURN, 11'd1010, 1'b1);
        send(KIND_SPEED, 16'h7FFF, 16'd0, 11'd0, 1'b0);
        send(KIND_SAMPLE, 16'd0, 16'd1, 11'd1024, 1'b1);
        send(KIND_TICK, 16'd0, 16'd0, 11'd0, 1'b0);

        for (int p = 2; p <= 8; p++) begin
            settle();
            cur = phase_setup(p);
            write_config(cur);
            run_phase(cur, PHASE_ITEMS);
        end
        settle();

        if (fail_count == 0)
            $display("[ttc_emergency_brake] OK");
        else
            $display("[ttc_emergency_brake] ERROR");
        $finish;
    end

endmodule
